@@ rtl/core/hotp_pkg.sv @@
// Package: shared types and constants for the one-time password checker.
`timescale 1ns / 1ps
`default_nettype none
package hotp_pkg;
  localparam int unsigned TimeStepDefault = 30;
  localparam int unsigned CodeMod = 1000000;
  localparam int unsigned StepW = 12;

  typedef enum logic [0:0] {
    OP_COUNTER = 1'b0,
    OP_TIME    = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic        op;
    logic [63:0] moving_value;
    logic [19:0] code;
  } in_word_t;

  typedef struct packed {
    logic        valid_res;
    logic [19:0] expected_code;
  } out_word_t;

  typedef struct packed {
    logic start;
  } sha_ctl_t;

  localparam logic [159:0] Sha1Iv =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
endpackage
`default_nettype wire

@@ rtl/core/hotp_sha1.sv @@
// SHA-1 compression unit: one round per cycle over a 16-word schedule window.
`timescale 1ns / 1ps
`default_nettype none
module hotp_sha1 (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hotp_pkg::sha_ctl_t ctl,
  input  wire logic [511:0]      blk,
  input  wire logic [159:0]      h_in,
  output logic [159:0]           h_out,
  output logic                   done
);
  import hotp_pkg::*;

  logic [511:0] w_r;
  logic [159:0] st_r, h_r;
  logic [6:0]   rnd_r;
  logic         busy_r, done_r;
  logic [31:0]  a, b, c, d, e, f, k, t, wnew;

  assign a = st_r[159:128];
  assign b = st_r[127:96];
  assign c = st_r[95:64];
  assign d = st_r[63:32];
  assign e = st_r[31:0];

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b & c) | (~b & d); k = 32'h5A827999;
    end else if (rnd_r < 7'd40) begin
      f = b ^ c ^ d; k = 32'h6ED9EBA1;
    end else if (rnd_r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d; k = 32'hCA62C1D6;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w_r[511:480];
    wnew = w_r[95:64] ^ w_r[255:224] ^ w_r[447:416] ^ w_r[511:480];
    wnew = {wnew[30:0], wnew[31]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
        w_r    <= blk;
        st_r   <= h_in;
        h_r    <= h_in;
      end else if (busy_r) begin
        w_r  <= {w_r[479:0], wnew};
        st_r <= {t, a, {b[1:0], b[31:2]}, c, d};
        if (rnd_r == 7'd79) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        rnd_r <= rnd_r + 7'd1;
      end
    end
  end

  assign h_out = {h_r[159:128] + st_r[159:128], h_r[127:96] + st_r[127:96],
                  h_r[95:64] + st_r[95:64], h_r[63:32] + st_r[63:32],
                  h_r[31:0] + st_r[31:0]};
  assign done = done_r;
endmodule
`default_nettype wire

@@ rtl/core/hotp_div.sv @@
// Constant divider step: reciprocal estimate, remainder, one correction over one multiplier.
`timescale 1ns / 1ps
`default_nettype none
module hotp_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [30:0] num,
  input  wire logic [19:0] divisor,
  input  wire logic [31:0] recip,
  output logic [30:0]      quotient,
  output logic [19:0]      remainder,
  output logic             done
);
  typedef enum logic [1:0] {
    PH_EST, PH_REM, PH_FIX
  } phase_t;

  phase_t       ph_r;
  logic [30:0]  num_r, q_r;
  logic [19:0]  d_r;
  logic [31:0]  m_r;
  logic [20:0]  r_r;
  logic         busy_r, done_r;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod;

  always_comb begin
    if (ph_r == PH_EST) begin
      mul_a = {1'b0, num_r};
      mul_b = m_r;
    end else begin
      mul_a = {1'b0, q_r};
      mul_b = {12'h0, d_r};
    end
    prod = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= PH_EST;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= PH_EST;
        num_r  <= num;
        d_r    <= divisor;
        m_r    <= recip;
      end else if (busy_r) begin
        case (ph_r)
          PH_EST: begin
            q_r  <= prod[61:31];
            ph_r <= PH_REM;
          end
          PH_REM: begin
            r_r  <= 21'(num_r - prod[30:0]);
            ph_r <= PH_FIX;
          end
          PH_FIX: begin
            if (r_r >= {1'b0, d_r}) begin
              q_r <= q_r + 31'd1;
              r_r <= r_r - {1'b0, d_r};
            end
            busy_r <= 1'b0;
            done_r <= 1'b1;
            ph_r   <= PH_EST;
          end
          default: ph_r <= PH_EST;
        endcase
      end
    end
  end

  assign quotient  = q_r;
  assign remainder = r_r[19:0];
  assign done      = done_r;
endmodule
`default_nettype wire

@@ rtl/core/hotp_totp_code_checker.sv @@
// Top level: HMAC-SHA1 one-time password check over a shared SHA-1 and divider.
//
//   channel | direction | handshake      | payload
//   in      | input     | in_valid/ready | op, moving_value, code
//   out     | output    | out_valid/ready| valid_res, expected_code
//   cfg     | input     | cfg_we         | key_high, key_low
//
// An item passes through four SHA-1 compressions, preceded in time mode by four
// divider steps for the time step, then a modulo by 1000000, from the accept in
// S_IDLE to the result in S_OUT.
// One item in flight; in_ready is low until the result is taken.
// Reset is synchronous; a stalled result holds in the output register.
`timescale 1ns / 1ps
`default_nettype none
module hotp_totp_code_checker #(
  parameter int unsigned TIME_STEP_SECONDS = hotp_pkg::TimeStepDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire hotp_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hotp_pkg::out_word_t      out_data,
  input  wire logic                cfg_we,
  input  wire hotp_pkg::cfg_idx_t  cfg_idx,
  input  wire logic [63:0]         cfg_wdata
);
  import hotp_pkg::*;

  localparam int unsigned StepEff = (TIME_STEP_SECONDS == 0) ? 1 : TIME_STEP_SECONDS;
  localparam logic [31:0] StepRecip = 32'((64'd1 << 31) / 64'(StepEff));
  localparam logic [31:0] ModRecip  = 32'((64'd1 << 31) / 64'(CodeMod));

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DIVW, S_I1, S_I2, S_O1, S_O2, S_MOD, S_MODW, S_OUT
  } state_t;

  state_t       state_r;
  logic [15:0]  key_high_r;
  logic [63:0]  key_low_r;
  logic [63:0]  fac_r;
  logic [19:0]  code_r;
  logic [StepW-1:0] rem_r;
  logic [31:0]  qacc_r;
  logic [1:0]   cnt_r;
  logic [159:0] hv_r, inner_r;
  out_word_t    out_r;
  logic         out_valid_r;
  sha_ctl_t     ctl;
  logic [511:0] blk;
  logic [159:0] h_out;
  logic         sha_done;
  logic         div_start, div_done;
  logic [30:0]  div_a, div_q;
  logic [19:0]  div_b, div_r;
  logic [31:0]  div_m;
  logic [79:0]  key;
  logic [511:0] kpad_i, kpad_o;
  logic [3:0]   off;
  logic [30:0]  bin;
  logic [159:0] macs;

  assign key    = {key_high_r, key_low_r};
  assign kpad_i = {key, 432'h0} ^ {64{8'h36}};
  assign kpad_o = {key, 432'h0} ^ {64{8'h5c}};

  always_comb begin
    case (state_r)
      S_I1:    blk = kpad_i;
      S_I2:    blk = {fac_r, 8'h80, 376'h0, 64'd576};
      S_O1:    blk = kpad_o;
      S_O2:    blk = {inner_r, 8'h80, 280'h0, 64'd672};
      default: blk = kpad_i;
    endcase
  end

  assign macs = h_out;
  assign off  = macs[3:0];
  assign bin  = 31'(macs >> (10'd128 - {off, 3'b000}));

  hotp_sha1 u_sha (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .blk(blk), .h_in(hv_r),
    .h_out(h_out), .done(sha_done)
  );

  hotp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_a),
    .divisor(div_b), .recip(div_m), .quotient(div_q), .remainder(div_r),
    .done(div_done)
  );

  assign div_start = (state_r == S_DIV) || (state_r == S_MOD);
  assign div_a = (state_r == S_MOD) ? bin :
                 {{(31 - StepW - 16){1'b0}}, rem_r, fac_r[63:48]};
  assign div_b = (state_r == S_MOD) ? 20'(CodeMod) : 20'(StepEff);
  assign div_m = (state_r == S_MOD) ? ModRecip : StepRecip;

  logic sha_wait_r;
  assign ctl.start   = !sha_wait_r && (state_r == S_I1 || state_r == S_I2 ||
                       state_r == S_O1 || state_r == S_O2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_high_r  <= '0;
      key_low_r   <= '0;
      out_valid_r <= 1'b0;
      sha_wait_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_KEY_HIGH: key_high_r <= cfg_wdata[15:0];
          CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (ctl.start) sha_wait_r <= 1'b1;
      case (state_r)
        S_IDLE: if (in_valid) begin
          fac_r  <= in_data.moving_value;
          code_r <= in_data.code;
          rem_r  <= '0;
          cnt_r  <= '0;
          hv_r   <= Sha1Iv;
          state_r <= (in_data.op == OP_TIME) ? S_DIV : S_I1;
        end
        S_DIV:  state_r <= S_DIVW;
        S_DIVW: if (div_done) begin
          rem_r  <= div_r[StepW-1:0];
          qacc_r <= {qacc_r[15:0], div_q[15:0]};
          if (cnt_r == 2'd3) begin
            fac_r   <= {32'h0, qacc_r[15:0], div_q[15:0]};
            state_r <= S_I1;
          end else begin
            fac_r   <= {fac_r[47:0], 16'h0};
            cnt_r   <= cnt_r + 2'd1;
            state_r <= S_DIV;
          end
        end
        S_I1: if (sha_done) begin
          hv_r <= h_out; sha_wait_r <= 1'b0; state_r <= S_I2;
        end
        S_I2: if (sha_done) begin
          inner_r <= h_out; hv_r <= Sha1Iv; sha_wait_r <= 1'b0; state_r <= S_O1;
        end
        S_O1: if (sha_done) begin
          hv_r <= h_out; sha_wait_r <= 1'b0; state_r <= S_O2;
        end
        S_O2: if (sha_done) begin
          sha_wait_r <= 1'b0; state_r <= S_MOD;
        end
        S_MOD:  state_r <= S_MODW;
        S_MODW: if (div_done) begin
          out_r.expected_code <= div_r;
          out_r.valid_res     <= (code_r == div_r);
          out_valid_r         <= 1'b1;
          state_r             <= S_OUT;
        end
        S_OUT: if (!out_valid_r || out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

@@ rtl/core/hotp_checker.sv @@
// Port checker for the one-time password block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module hotp_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire hotp_pkg::out_word_t out_data
);
  import hotp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed under stall");
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.expected_code < 20'd1000000)
    else $error("expected code out of range");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");
endmodule

bind hotp_totp_code_checker hotp_checker u_hotp_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
